>>> sv/clle_pkg.sv
package clle_pkg;

    // Operation codes carried in the operation field of an input transaction.
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_NEXT   = 3'd2;
    localparam logic [2:0] OP_PREV   = 3'd3;
    localparam logic [2:0] OP_START  = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    // Status codes reported with every result.
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] value;
    } clle_item_t;

    typedef struct packed {
        logic signed [31:0] current_value;
        logic               current_valid;
        logic [7:0]         element_count;
        logic [1:0]         status;
    } clle_result_t;

endpackage

>>> sv/clle_ram.sv
module clle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Simple dual-port array: one write, one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/cursor_linked_list_engine.sv
// Bounded singly linked list with a header node and a cursor.
//
// Command channel: a transaction is taken at a rising edge where start is high
// and busy is low; item carries the operation and, for insert, the value.
// Result channel: done is high for exactly one cycle while result holds the
// element after the cursor, its valid flag, the element count and a status.
// The receiver cannot stall the block, so each result must be captured in the
// cycle that done marks it; the block never waits on the far side.
// Sequencing from acceptance to done: an insert at the header finishes in S_INS,
// one elsewhere goes on through S_LNK, and a reused free node is first popped in
// S_POP; remove runs S_REM, S_UNL, S_FREE and S_VAL; next runs S_STEP, S_FV and
// S_VAL; move-to-start, clear and refused operations run S_FV and S_VAL; prev
// walks the links from the header in S_WALK before S_VAL. Each dependent pointer
// fetch waits on the registered read of the single read port of the link memory.
// Only one transaction is in flight; busy falls in the cycle done is shown,
// so a new command may be taken while the previous result is on the ports.
// Reset returns the list to empty with the cursor on the header node. The
// node memories need no clearing pass: the header's link lives in a register.
module cursor_linked_list_engine
    import clle_pkg::*;
#(
    parameter int NODE_COUNT = 256,
    parameter int VALUE_BITS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  clle_item_t   item,
    output logic         done,
    output clle_result_t result
);

    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_COUNT - 1);
    localparam logic [IDX_W:0]   NODE_TOTAL = (IDX_W + 1)'(NODE_COUNT);

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_POP  = 12'b0000_0000_0010,
        S_INS  = 12'b0000_0000_0100,
        S_LNK  = 12'b0000_0000_1000,
        S_REM  = 12'b0000_0001_0000,
        S_UNL  = 12'b0000_0010_0000,
        S_FREE = 12'b0000_0100_0000,
        S_STEP = 12'b0000_1000_0000,
        S_WALK = 12'b0001_0000_0000,
        S_FIN  = 12'b0010_0000_0000,
        S_FV   = 12'b0100_0000_0000,
        S_VAL  = 12'b1000_0000_0000
    } state_t;

    // Control state, initialised by reset.
    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [IDX_W-1:0]  cursor_reg, cursor_next;
    logic [IDX_W-1:0]  size_reg, size_next;
    logic [IDX_W:0]    fresh_reg, fresh_next;
    logic [IDX_W-1:0]  free_top_reg, free_top_next;
    logic [IDX_W-1:0]  free_depth_reg, free_depth_next;
    logic [IDX_W-1:0]  head_link_reg, head_link_next;
    logic              done_reg, done_next;

    // Working registers of the transaction in flight.
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [IDX_W-1:0]      node_reg, node_next;
    logic [IDX_W-1:0]      victim_reg, victim_next;
    logic [IDX_W-1:0]      after_reg, after_next;
    logic [IDX_W-1:0]      walk_reg, walk_next;
    logic [IDX_W-1:0]      steps_reg, steps_next;
    logic [1:0]            status_reg, status_next;
    clle_result_t          result_reg, result_next;

    // Memory ports.
    logic                  link_we;
    logic [IDX_W-1:0]      link_waddr;
    logic [IDX_W-1:0]      link_wdata;
    logic [IDX_W-1:0]      link_raddr;
    logic [IDX_W-1:0]      link_rdata;
    logic                  vmem_we;
    logic [VALUE_BITS-1:0] vmem_rdata;

    // Helpers.
    logic [IDX_W-1:0]      link_cur;
    logic [IDX_W-1:0]      walk_succ;
    logic [IDX_W-1:0]      size_inc;
    logic [IDX_W+7:0]      count_cur_wide;
    logic [IDX_W+7:0]      count_inc_wide;
    logic [VALUE_BITS+31:0] value_in_wide;
    logic [VALUE_BITS+31:0] value_mem_wide;
    logic [VALUE_BITS+31:0] value_reg_wide;
    logic [IDX_W:0]        node_ledger;

    // The link memory holds the successor of every element node. The header's
    // successor sits in head_link_reg so that reset and clear need no memory pass.
    clle_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NODE_COUNT)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_we),
        .wr_addr (link_waddr),
        .wr_data (link_wdata),
        .rd_addr (link_raddr),
        .rd_data (link_rdata)
    );

    // The value memory is written only by insert and read with the address
    // of the element after the cursor, so its read data lines up with after_reg.
    clle_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (NODE_COUNT)
    ) u_value_ram (
        .clk     (clk),
        .wr_en   (vmem_we),
        .wr_addr (node_reg),
        .wr_data (val_reg),
        .rd_addr (after_next),
        .rd_data (vmem_rdata)
    );

    // Successor of the cursor, valid in any state entered after a read of
    // the cursor's link was issued.
    assign link_cur  = (cursor_reg == '0) ? head_link_reg : link_rdata;
    assign walk_succ = (walk_reg == '0) ? head_link_reg : link_rdata;

    assign size_inc       = size_reg + 1'b1;
    assign count_cur_wide = {8'b0, size_reg};
    assign count_inc_wide = {8'b0, size_inc};

    // Values are stored in VALUE_BITS bits and reported in the low 32 bits.
    assign value_in_wide  = {{VALUE_BITS{1'b0}}, item.value};
    assign value_mem_wide = {32'b0, vmem_rdata};
    assign value_reg_wide = {32'b0, val_reg};

    always_comb
    begin
        state_next      = state_reg;
        tail_next       = tail_reg;
        cursor_next     = cursor_reg;
        size_next       = size_reg;
        fresh_next      = fresh_reg;
        free_top_next   = free_top_reg;
        free_depth_next = free_depth_reg;
        head_link_next  = head_link_reg;
        done_next       = 1'b0;
        val_next        = val_reg;
        node_next       = node_reg;
        victim_next     = victim_reg;
        after_next      = after_reg;
        walk_next       = walk_reg;
        steps_next      = steps_reg;
        status_next     = status_reg;
        result_next     = result_reg;
        link_we         = 1'b0;
        link_waddr      = cursor_reg;
        link_wdata      = node_reg;
        link_raddr      = cursor_reg;
        vmem_we         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    val_next    = value_in_wide[VALUE_BITS-1:0];
                    status_next = ST_DONE;
                    case (item.operation)
                        OP_INSERT:
                        begin
                            if (size_reg >= LAST_IDX
                                || (free_depth_reg == '0 && fresh_reg >= NODE_TOTAL))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_FV;
                            end
                            else if (free_depth_reg != '0)
                            begin
                                // Fetch the link of the free stack's top first.
                                link_raddr = free_top_reg;
                                state_next = S_POP;
                            end
                            else
                            begin
                                node_next  = fresh_reg[IDX_W-1:0];
                                fresh_next = fresh_reg + 1'b1;
                                state_next = S_INS;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (cursor_reg == tail_reg)
                            begin
                                status_next = ST_IGNORED;
                                state_next  = S_FV;
                            end
                            else
                            begin
                                state_next = S_REM;
                            end
                        end
                        OP_NEXT:
                        begin
                            if (cursor_reg == tail_reg)
                            begin
                                status_next = ST_IGNORED;
                                state_next  = S_FV;
                            end
                            else
                            begin
                                state_next = S_STEP;
                            end
                        end
                        OP_PREV:
                        begin
                            if (cursor_reg == '0)
                            begin
                                status_next = ST_IGNORED;
                                state_next  = S_FV;
                            end
                            else
                            begin
                                walk_next  = '0;
                                steps_next = '0;
                                state_next = S_WALK;
                            end
                        end
                        OP_START:
                        begin
                            cursor_next = '0;
                            state_next  = S_FV;
                        end
                        OP_CLEAR:
                        begin
                            tail_next       = '0;
                            cursor_next     = '0;
                            size_next       = '0;
                            fresh_next      = (IDX_W + 1)'(1);
                            free_top_next   = '0;
                            free_depth_next = '0;
                            head_link_next  = '0;
                            state_next      = S_FV;
                        end
                        default:
                        begin
                            status_next = ST_IGNORED;
                            state_next  = S_FV;
                        end
                    endcase
                end
            end

            S_POP:
            begin
                node_next       = free_top_reg;
                free_top_next   = link_rdata;
                free_depth_next = free_depth_reg - 1'b1;
                link_raddr      = cursor_reg;
                state_next      = S_INS;
            end

            S_INS:
            begin
                link_we    = 1'b1;
                link_waddr = node_reg;
                link_wdata = link_cur;
                vmem_we    = 1'b1;
                if (tail_reg == cursor_reg)
                begin
                    tail_next = node_reg;
                end
                size_next = size_inc;
                result_next.current_value = value_reg_wide[31:0];
                result_next.current_valid = 1'b1;
                result_next.element_count = count_inc_wide[7:0];
                result_next.status        = ST_DONE;
                if (cursor_reg == '0)
                begin
                    head_link_next = node_reg;
                    done_next      = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_LNK;
                end
            end

            S_LNK:
            begin
                link_we    = 1'b1;
                link_waddr = cursor_reg;
                link_wdata = node_reg;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_REM:
            begin
                if (link_cur == '0)
                begin
                    status_next = ST_IGNORED;
                    state_next  = S_FV;
                end
                else
                begin
                    victim_next = link_cur;
                    link_raddr  = link_cur;
                    if (tail_reg == link_cur)
                    begin
                        tail_next = cursor_reg;
                    end
                    state_next = S_UNL;
                end
            end

            S_UNL:
            begin
                // Bypass the victim: the cursor now points at its successor.
                if (cursor_reg == '0)
                begin
                    head_link_next = link_rdata;
                end
                else
                begin
                    link_we    = 1'b1;
                    link_waddr = cursor_reg;
                    link_wdata = link_rdata;
                end
                after_next = link_rdata;
                state_next = S_FREE;
            end

            S_FREE:
            begin
                // Push the victim on the free stack threaded through the links.
                link_we         = 1'b1;
                link_waddr      = victim_reg;
                link_wdata      = free_top_reg;
                free_top_next   = victim_reg;
                free_depth_next = free_depth_reg + 1'b1;
                size_next       = size_reg - 1'b1;
                state_next      = S_VAL;
            end

            S_STEP:
            begin
                cursor_next = link_cur;
                link_raddr  = link_cur;
                state_next  = S_FV;
            end

            S_WALK:
            begin
                if (walk_succ == cursor_reg || walk_succ == '0)
                begin
                    // The walk's node is the new cursor and its link is known.
                    cursor_next = walk_reg;
                    after_next  = walk_succ;
                    state_next  = S_VAL;
                end
                else if (steps_reg == LAST_IDX)
                begin
                    cursor_next = walk_succ;
                    state_next  = S_FIN;
                end
                else
                begin
                    walk_next  = walk_succ;
                    steps_next = steps_reg + 1'b1;
                    link_raddr = walk_succ;
                end
            end

            S_FIN:
            begin
                link_raddr = cursor_reg;
                state_next = S_FV;
            end

            S_FV:
            begin
                after_next = link_cur;
                state_next = S_VAL;
            end

            S_VAL:
            begin
                if (after_reg != '0)
                begin
                    result_next.current_value = value_mem_wide[31:0];
                    result_next.current_valid = 1'b1;
                end
                else
                begin
                    result_next.current_value = '0;
                    result_next.current_valid = 1'b0;
                end
                result_next.element_count = count_cur_wide[7:0];
                result_next.status        = status_reg;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tail_reg       <= '0;
            cursor_reg     <= '0;
            size_reg       <= '0;
            fresh_reg      <= (IDX_W + 1)'(1);
            free_top_reg   <= '0;
            free_depth_reg <= '0;
            head_link_reg  <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tail_reg       <= tail_next;
            cursor_reg     <= cursor_next;
            size_reg       <= size_next;
            fresh_reg      <= fresh_next;
            free_top_reg   <= free_top_next;
            free_depth_reg <= free_depth_next;
            head_link_reg  <= head_link_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg    <= val_next;
        node_reg   <= node_next;
        victim_reg <= victim_next;
        after_reg  <= after_next;
        walk_reg   <= walk_next;
        steps_reg  <= steps_next;
        status_reg <= status_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Every node handed out is either in the list or on the free stack.
    assign node_ledger = {1'b0, free_depth_reg} + {1'b0, size_reg} + (IDX_W + 1)'(1);

    // Every command passes through at least one state besides idle, so strobes never abut.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe held for more than one cycle");

    // An accepted command must occupy the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("command accepted but sequencer stayed idle");

    // Between commands, list size and free stack depth account for all nodes used.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (node_ledger == fresh_reg))
        else $error("node accounting broken between list, free stack and fresh pointer");

endmodule

>>> dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import clle_pkg::*;

    // The block is built with its default sizes, so the predictor uses the same ones.
    localparam int NODE_COUNT = 256;

    // The two spare operation codes. The block must refuse them and change nothing.
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // Watchdog limit on the run of cycles with no accepted transaction and no result.
    // It sits well above a prev walk over a full list, the sender's longest gap and
    // the tail wait.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 1950;
    localparam int FILL_ITEMS     = NODE_COUNT + 2;

    typedef enum
    {
        MIX_ALL,
        MIX_GROW,
        MIX_WALK,
        MIX_SHRINK
    } stim_mode_t;

    // One row of the directed stimulus. Where pinned is set, the expected result
    // is typed into the row. Otherwise the result comes from the list predictor.
    typedef struct {
        clle_item_t   cmd;
        bit           pinned;
        clle_result_t want;
    } stim_row_t;

    logic         clk   = 1'b0;
    logic         rst_n = 1'b0;
    logic         start = 1'b0;
    clle_item_t   item  = '0;
    logic         busy;
    logic         done;
    clle_result_t result;

    cursor_linked_list_engine u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always #2 clk = ~clk;

    // Shadow copy of the list. Node 0 is the header. Links of zero end the list.
    // The freed nodes form a stack that is threaded through the link array.
    bit [31:0] node_store [NODE_COUNT];
    bit [7:0]  node_next  [NODE_COUNT];
    bit [7:0]  list_tail;
    bit [7:0]  list_cursor;
    int        list_len;
    int        fresh_slot;
    bit [7:0]  free_head;
    int        free_count;

    clle_result_t pending_results[$];
    clle_result_t head_result;
    stim_row_t    stim_rows[$];
    int           error_count = 0;
    int           idle_cycles = 0;
    int           burst_left  = 0;

    function automatic void list_wipe();
        foreach (node_next[i])
        begin
            node_next[i]  = '0;
            node_store[i] = '0;
        end
        list_tail   = '0;
        list_cursor = '0;
        list_len    = 0;
        fresh_slot  = 1;
        free_head   = '0;
        free_count  = 0;
    endfunction

    // Applies one command to the shadow list and returns the result that the
    // block must report for it.
    function automatic clle_result_t list_apply(clle_item_t cmd);
        clle_result_t res;
        logic [1:0]   st;
        bit [7:0]     node;
        bit [7:0]     walk;
        bit [7:0]     nxt;
        bit           found;
        int           steps;
        st   = ST_DONE;
        node = '0;
        case (cmd.operation)
            OP_INSERT:
            begin
                if (list_len >= NODE_COUNT - 1)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    if (free_count > 0)
                    begin
                        node       = free_head;
                        free_head  = node_next[node];
                        free_count = free_count - 1;
                    end
                    else if (fresh_slot >= NODE_COUNT)
                    begin
                        st = ST_FULL;
                    end
                    else
                    begin
                        node       = fresh_slot[7:0];
                        fresh_slot = fresh_slot + 1;
                    end
                    if (st == ST_DONE && node == 0)
                        st = ST_FULL;
                    if (st == ST_DONE)
                    begin
                        node_store[node]       = cmd.value;
                        node_next[node]        = node_next[list_cursor];
                        node_next[list_cursor] = node;
                        if (list_tail == list_cursor)
                            list_tail = node;
                        list_len = list_len + 1;
                    end
                end
            end
            OP_REMOVE:
            begin
                node = node_next[list_cursor];
                if (list_cursor == list_tail || node == 0)
                begin
                    st = ST_IGNORED;
                end
                else
                begin
                    if (list_tail == node)
                        list_tail = list_cursor;
                    node_next[list_cursor] = node_next[node];
                    node_next[node]        = free_head;
                    free_head              = node;
                    free_count             = free_count + 1;
                    list_len               = list_len - 1;
                end
            end
            OP_NEXT:
            begin
                if (list_cursor == list_tail)
                    st = ST_IGNORED;
                else
                    list_cursor = node_next[list_cursor];
            end
            OP_PREV:
            begin
                if (list_cursor == 0)
                begin
                    st = ST_IGNORED;
                end
                else
                begin
                    walk  = '0;
                    found = 1'b0;
                    steps = 0;
                    while (steps < NODE_COUNT && !found)
                    begin
                        nxt = node_next[walk];
                        if (nxt == list_cursor || nxt == 0)
                            found = 1'b1;
                        else
                            walk = nxt;
                        steps = steps + 1;
                    end
                    list_cursor = walk;
                end
            end
            OP_START:
            begin
                list_cursor = '0;
            end
            OP_CLEAR:
            begin
                list_wipe();
            end
            default:
            begin
                st = ST_IGNORED;
            end
        endcase
        node = node_next[list_cursor];
        res.current_value = (node != 0) ? node_store[node] : '0;
        res.current_valid = (node != 0);
        res.element_count = list_len[7:0];
        res.status        = st;
        return res;
    endfunction

    function automatic void add_row(logic [2:0] op, logic [31:0] val, bit pinned,
                                    logic [31:0] cur, logic vld, logic [7:0] cnt,
                                    logic [1:0] st);
        stim_row_t row;
        row.cmd.operation      = op;
        row.cmd.value          = val;
        row.pinned             = pinned;
        row.want.current_value = cur;
        row.want.current_valid = vld;
        row.want.element_count = cnt;
        row.want.status        = st;
        stim_rows.push_back(row);
    endfunction

    // Values lean towards the extremes of the signed range, with plenty of noise.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Each mode biases the operation mix. Growing builds long lists, walking moves
    // the cursor deep and back, shrinking empties the list to reach both ends.
    function automatic clle_item_t pick_command(stim_mode_t mode);
        clle_item_t cmd;
        int         roll;
        roll          = $urandom_range(0, 99);
        cmd.value     = pick_value();
        cmd.operation = OP_INSERT;
        case (mode)
            MIX_GROW:
            begin
                if (roll < 70)      cmd.operation = OP_INSERT;
                else if (roll < 90) cmd.operation = OP_NEXT;
                else if (roll < 95) cmd.operation = OP_PREV;
                else                cmd.operation = OP_START;
            end
            MIX_WALK:
            begin
                if (roll < 40)      cmd.operation = OP_NEXT;
                else if (roll < 70) cmd.operation = OP_PREV;
                else if (roll < 80) cmd.operation = OP_START;
                else if (roll < 90) cmd.operation = OP_INSERT;
                else                cmd.operation = OP_REMOVE;
            end
            MIX_SHRINK:
            begin
                if (roll < 60)      cmd.operation = OP_REMOVE;
                else if (roll < 70) cmd.operation = OP_START;
                else if (roll < 85) cmd.operation = OP_NEXT;
                else if (roll < 95) cmd.operation = OP_PREV;
                else                cmd.operation = OP_INSERT;
            end
            default:
            begin
                if (roll < 38)      cmd.operation = OP_INSERT;
                else if (roll < 58) cmd.operation = OP_REMOVE;
                else if (roll < 78) cmd.operation = OP_NEXT;
                else if (roll < 88) cmd.operation = OP_PREV;
                else if (roll < 95) cmd.operation = OP_START;
                else if (roll < 96) cmd.operation = OP_CLEAR;
                else if (roll < 98) cmd.operation = OP_SPARE_LO;
                else                cmd.operation = OP_SPARE_HI;
            end
        endcase
        return cmd;
    endfunction

    // Presents one command and returns at the rising edge where it is taken.
    // Start is only lowered when a gap opens, and only raised again at a later
    // falling edge, so it never sees two assignments in one time step.
    task automatic send_command(clle_item_t cmd);
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        burst_left = burst_left - 1;
        @(negedge clk);
        start <= 1'b1;
        item  <= cmd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Sends a command and files the result that it must produce. The predictor
    // always runs so that the shadow list stays in step, but a pinned row
    // supplies its own expectation.
    task automatic issue(clle_item_t cmd, bit pinned, clle_result_t want);
        clle_result_t predicted;
        send_command(cmd);
        predicted = list_apply(cmd);
        pending_results.push_back(pinned ? want : predicted);
    endtask

    // Holds the sender off until every outstanding transaction has reported.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count = error_count + 1;
        end
    endfunction

    // Results cannot be held off, so every strobe is compared with the oldest
    // expectation in the same cycle that it appears.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result strobe with no transaction outstanding");
                error_count = error_count + 1;
            end
            else
            begin
                head_result = pending_results.pop_front();
                check_field("current_value", head_result.current_value,
                            result.current_value);
                check_field("current_valid", head_result.current_valid,
                            result.current_valid);
                check_field("element_count", head_result.element_count,
                            result.element_count);
                check_field("status", head_result.status, result.status);
            end
        end
    end

    // Ends the run if neither side of the block moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        clle_item_t   cmd;
        clle_result_t blank;
        int           counted;
        int           seg_len;
        int           k;
        stim_mode_t   mode;

        blank = '0;
        list_wipe();

        // Directed rows. The empty list after reset refuses every move at its
        // ends, the extremes of the signed range are inserted at the header, and
        // the rest exercises the ends of a short list, reuse of a freed node,
        // the spare codes and clear.
        add_row(OP_NEXT,     32'h0,         1, 32'h0,         0, 8'd0, ST_IGNORED);
        add_row(OP_PREV,     32'h0,         1, 32'h0,         0, 8'd0, ST_IGNORED);
        add_row(OP_REMOVE,   32'h0,         1, 32'h0,         0, 8'd0, ST_IGNORED);
        add_row(OP_START,    32'h0,         1, 32'h0,         0, 8'd0, ST_DONE);
        add_row(OP_INSERT,   32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1, 8'd1, ST_DONE);
        add_row(OP_INSERT,   32'h8000_0000, 1, 32'h8000_0000, 1, 8'd2, ST_DONE);
        add_row(OP_NEXT,     32'h0,         0, 32'h0,         0, 8'd0, ST_DONE);
        add_row(OP_NEXT,     32'h0,         0, 32'h0,         0, 8'd0, ST_DONE);
        add_row(OP_NEXT,     32'h0,         0, 32'h0,         0, 8'd0, ST_DONE);
        add_row(OP_REMOVE,   32'h0,         0, 32'h0,         0, 8'd0, ST_DONE);
        add_row(OP_PREV,     32'h0,         0, 32'h0,         0, 8'd0, ST_DONE);
        add_row(OP_PREV,     32'h0,         0, 32'h0,         0, 8'd0, ST_DONE);
        add_row(OP_INSERT,   32'h0000_0000, 0, 32'h0,         0, 8'd0, ST_DONE);
        add_row(OP_INSERT,   32'hFFFF_FFFF, 0, 32'h0,         0, 8'd0, ST_DONE);
        add_row(OP_REMOVE,   32'h0,         0, 32'h0,         0, 8'd0, ST_DONE);
        add_row(OP_INSERT,   32'h1234_5678, 0, 32'h0,         0, 8'd0, ST_DONE);
        add_row(OP_START,    32'h0,         0, 32'h0,         0, 8'd0, ST_DONE);
        add_row(OP_REMOVE,   32'h0,         0, 32'h0,         0, 8'd0, ST_DONE);
        add_row(OP_SPARE_LO, 32'h0,         0, 32'h0,         0, 8'd0, ST_DONE);
        add_row(OP_SPARE_HI, 32'hFFFF_FFFF, 0, 32'h0,         0, 8'd0, ST_DONE);
        add_row(OP_CLEAR,    32'h0,         1, 32'h0,         0, 8'd0, ST_DONE);
        add_row(OP_INSERT,   32'h5555_5555, 0, 32'h0,         0, 8'd0, ST_DONE);
        add_row(OP_NEXT,     32'h0,         0, 32'h0,         0, 8'd0, ST_DONE);
        add_row(OP_INSERT,   32'hAAAA_AAAA, 0, 32'h0,         0, 8'd0, ST_DONE);
        add_row(OP_CLEAR,    32'h0,         1, 32'h0,         0, 8'd0, ST_DONE);

        // Reset is applied once and released at a falling edge.
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[i])
            issue(stim_rows[i].cmd, stim_rows[i].pinned, stim_rows[i].want);

        // Fill the empty list to capacity and then push past it, so that the
        // refusal of an insert into a full list is seen a few times.
        counted = 0;
        for (k = 0; k < FILL_ITEMS; k++)
        begin
            cmd.operation = OP_INSERT;
            cmd.value     = pick_value();
            issue(cmd, 0, blank);
            counted = counted + 1;
        end
        drain_results();

        // Random segments, each with its own operation mix. The first one walks
        // the full list so that prev covers long chains. Every transaction,
        // refused or not, counts towards the item total.
        mode = MIX_WALK;
        while (counted < RANDOM_ITEMS)
        begin
            seg_len = $urandom_range(40, 200);
            for (k = 0; k < seg_len && counted < RANDOM_ITEMS; k++)
            begin
                issue(pick_command(mode), 0, blank);
                counted = counted + 1;
            end
            if ($urandom_range(0, 3) == 0)
                drain_results();
            case ($urandom_range(0, 5))
                0, 1:    mode = MIX_ALL;
                2:       mode = MIX_GROW;
                3, 4:    mode = MIX_WALK;
                default: mode = MIX_SHRINK;
            endcase
        end

        // Wait for the last results, then long enough for a full prev walk so
        // that any stray strobe would still be caught.
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
